// ===== rtl/core/bn254_field_alu_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the BN254 field ALU
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BN254_FIELD_ALU_ASSERT_SVH
`define BN254_FIELD_ALU_ASSERT_SVH

// check the consequent in the same cycle as the antecedent
`define BFA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check the consequent in the cycle after the antecedent
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Constants, types and word helpers shared by the BN254 field ALU.
// ----------------------------------------------------------------------------
package bfa_pkg;

	localparam int unsigned NWORDS = 8;
	localparam int unsigned WW     = 32;
	localparam int unsigned OPW    = NWORDS * WW;
	// running CIOS value stays below 2^258
	localparam int unsigned TW     = 258;
	// accumulator width for value plus two shifted product rows
	localparam int unsigned SW     = 291;

	localparam logic [OPW-1:0] PRIME =
		256'h30644e72e131a029b85045b68181585d97816a916871ca8d3c208c16d87cfd47;
	localparam logic [WW-1:0]  NEG_PINV = 32'he4866389;

	localparam logic [1:0] ACT_ADD = 2'd0;
	localparam logic [1:0] ACT_SUB = 2'd1;
	localparam logic [1:0] ACT_NEG = 2'd2;
	localparam logic [1:0] ACT_MUL = 2'd3;

	typedef logic [2*WW-1:0] dword_t;
	typedef dword_t [NWORDS-1:0] pp_t;

	typedef struct packed {
		logic [1:0]     action;
		logic [OPW-1:0] a;
		logic [OPW-1:0] b;
		logic [TW-1:0]  t;
		pp_t            pp;
	} round_bus_t;

	// one 32x32 product per word of u
	function automatic pp_t word_products(input logic [OPW-1:0] u, input logic [WW-1:0] w);
		pp_t r;
		for (int j = 0; j < NWORDS; j++) begin
			r[j] = dword_t'(u[WW*j +: WW]) * dword_t'(w);
		end
		return r;
	endfunction

	// add a row of word products, each at its word offset, to base
	function automatic logic [SW-1:0] accumulate(input logic [SW-1:0] base, input pp_t pp);
		logic [SW-1:0] lo;
		logic [SW-1:0] hi;
		lo = '0;
		hi = '0;
		for (int j = 0; j < NWORDS; j++) begin
			lo[WW*j +: WW]     = pp[j][WW-1:0];
			hi[WW*(j+1) +: WW] = pp[j][2*WW-1:WW];
		end
		return base + lo + hi;
	endfunction

endpackage

// ===== rtl/core/bn254_field_alu.sv =====
// ----------------------------------------------------------------------------
// bn254_field_alu
// Modular add, subtract, negate and Montgomery multiply over the BN254 prime.
// ----------------------------------------------------------------------------
// A new word may enter in every cycle unless in_stall is high. The pipeline
// depth is set by the multiply: one entry stage forms the first a*b_0 row,
// eight CIOS rounds of four stages each (product row add, m multiply, m*p
// multiply, add and shift) follow, then two stages prepare and apply the
// final subtract. Add, subtract and negate ride the same pipeline so results
// leave in order. A stall at the output backs up only through full stages;
// empty stages keep filling.
// ----------------------------------------------------------------------------
module bn254_field_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [63:0] a_limb_0,
	input  logic [63:0] a_limb_1,
	input  logic [63:0] a_limb_2,
	input  logic [61:0] a_limb_3,
	input  logic [63:0] b_limb_0,
	input  logic [63:0] b_limb_1,
	input  logic [63:0] b_limb_2,
	input  logic [61:0] b_limb_3,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] r_limb_0,
	output logic [63:0] r_limb_1,
	output logic [63:0] r_limb_2,
	output logic [61:0] r_limb_3
);

	`include "bn254_field_alu_assert.svh"

	localparam logic MODE_CSUB = 1'b0;
	localparam logic MODE_SUB  = 1'b1;

	logic [bfa_pkg::OPW-1:0] a_in, b_in;

	logic                vld_s0, rdy_s0;
	bfa_pkg::round_bus_t bus_s0;

	bfa_pkg::round_bus_t rbus [0:bfa_pkg::NWORDS];
	logic                rvld [0:bfa_pkg::NWORDS];
	logic                rrdy [0:bfa_pkg::NWORDS];

	logic                    vld_s33, rdy_s33, mode_s33;
	logic [bfa_pkg::OPW-1:0] x_s33, y_s33;
	logic                    vld_s34, rdy_s34;
	logic [bfa_pkg::OPW-1:0] r_s34;

	logic                    mode_nx;
	logic [bfa_pkg::OPW-1:0] x_nx, y_nx;
	logic [bfa_pkg::OPW:0]   dp;
	logic [bfa_pkg::OPW-1:0] r_nx;

	assign a_in = {2'b00, a_limb_3, a_limb_2, a_limb_1, a_limb_0};
	assign b_in = {2'b00, b_limb_3, b_limb_2, b_limb_1, b_limb_0};

	// backpressure chain
	assign rdy_s34  = !vld_s34 || !out_stall;
	assign rdy_s33  = !vld_s33 || rdy_s34;
	assign rdy_s0   = !vld_s0 || rrdy[0];
	assign in_stall = !rdy_s0;

	// entry stage: capture operands and the first a*b_0 row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (rdy_s0) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s0) begin
			bus_s0.action <= action;
			bus_s0.a      <= a_in;
			bus_s0.b      <= b_in;
			bus_s0.t      <= '0;
			bus_s0.pp     <= bfa_pkg::word_products(a_in, b_in[bfa_pkg::WW-1:0]);
		end
	end

	assign rbus[0] = bus_s0;
	assign rvld[0] = vld_s0;
	assign rrdy[bfa_pkg::NWORDS] = rdy_s33;

	// CIOS rounds
	for (genvar g = 0; g < bfa_pkg::NWORDS; g++) begin : g_round
		bfa_mont_round #(.IDX(g)) u_round (
			.clk    (clk),
			.arst_n (arst_n),
			.in_vld (rvld[g]),
			.in_bus (rbus[g]),
			.in_rdy (rrdy[g]),
			.out_vld(rvld[g+1]),
			.out_bus(rbus[g+1]),
			.out_rdy(rrdy[g+1])
		);
	end

	// pick minuend and subtrahend for the final step
	always_comb begin
		x_nx    = '0;
		y_nx    = '0;
		mode_nx = MODE_CSUB;
		unique case (rbus[bfa_pkg::NWORDS].action)
			bfa_pkg::ACT_ADD: begin
				x_nx    = rbus[bfa_pkg::NWORDS].a + rbus[bfa_pkg::NWORDS].b;
				mode_nx = MODE_CSUB;
			end
			bfa_pkg::ACT_SUB: begin
				if (rbus[bfa_pkg::NWORDS].a < rbus[bfa_pkg::NWORDS].b) begin
					x_nx = rbus[bfa_pkg::NWORDS].a + bfa_pkg::PRIME;
				end else begin
					x_nx = rbus[bfa_pkg::NWORDS].a;
				end
				y_nx    = rbus[bfa_pkg::NWORDS].b;
				mode_nx = MODE_SUB;
			end
			bfa_pkg::ACT_NEG: begin
				x_nx    = (rbus[bfa_pkg::NWORDS].a == '0) ? '0 : bfa_pkg::PRIME;
				y_nx    = rbus[bfa_pkg::NWORDS].a;
				mode_nx = MODE_SUB;
			end
			bfa_pkg::ACT_MUL: begin
				x_nx    = rbus[bfa_pkg::NWORDS].t[bfa_pkg::OPW-1:0];
				mode_nx = MODE_CSUB;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s33 <= 1'b0;
			vld_s34 <= 1'b0;
		end else begin
			if (rdy_s33) vld_s33 <= rvld[bfa_pkg::NWORDS];
			if (rdy_s34) vld_s34 <= vld_s33;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s33) begin
			x_s33    <= x_nx;
			y_s33    <= y_nx;
			mode_s33 <= mode_nx;
		end
	end

	// subtract, or subtract p once when not short
	assign dp = {1'b0, x_s33} - {1'b0, bfa_pkg::PRIME};

	always_comb begin
		unique case (mode_s33)
			MODE_SUB:  r_nx = x_s33 - y_s33;
			MODE_CSUB: r_nx = dp[bfa_pkg::OPW] ? x_s33 : dp[bfa_pkg::OPW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s34) begin
			r_s34 <= r_nx;
		end
	end

	assign out_valid = vld_s34;
	assign r_limb_0  = r_s34[63:0];
	assign r_limb_1  = r_s34[127:64];
	assign r_limb_2  = r_s34[191:128];
	assign r_limb_3  = r_s34[253:192];

	`BFA_ASSERT_SAME(a_stall_origin, in_stall, out_valid && out_stall, "input stalled without a blocked output word")
	`BFA_ASSERT_NEXT(a_take_word, in_valid && !in_stall, vld_s0, "accepted word missing from entry stage")
	`BFA_ASSERT_NEXT(a_hold_s33, vld_s33 && !rdy_s34, vld_s33 && $stable(x_s33) && $stable(mode_s33), "blocked final stage changed")

endmodule

// ===== rtl/core/bfa_mont_round.sv =====
// ----------------------------------------------------------------------------
// bfa_mont_round
// One CIOS round of the Montgomery multiply in four register stages:
// add a*b_i, form m, form m*p, add and shift down one word.
// ----------------------------------------------------------------------------
module bfa_mont_round #(
	parameter int unsigned IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  bfa_pkg::round_bus_t in_bus,
	output logic                in_rdy,
	output logic                out_vld,
	output bfa_pkg::round_bus_t out_bus,
	input  logic                out_rdy
);

	localparam int unsigned NXT = (IDX + 1) % bfa_pkg::NWORDS;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic [1:0]              act_s1, act_s2, act_s3, act_s4;
	logic [bfa_pkg::OPW-1:0] a_s1, a_s2, a_s3, a_s4;
	logic [bfa_pkg::OPW-1:0] b_s1, b_s2, b_s3, b_s4;
	logic [bfa_pkg::SW-1:0]  s_s1, s_s2, s_s3;
	logic [bfa_pkg::WW-1:0]  m_s2;
	bfa_pkg::pp_t            qq_s3;
	logic [bfa_pkg::TW-1:0]  t_s4;
	bfa_pkg::pp_t            pp_s4;

	logic [2*bfa_pkg::WW-1:0] m_prod;
	logic [bfa_pkg::SW-1:0]   s_sum;

	// advance a stage when it is empty or its successor advances
	assign rdy_s4 = !vld_s4 || out_rdy;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign in_rdy = rdy_s1;

	assign m_prod = (2*bfa_pkg::WW)'(s_s1[bfa_pkg::WW-1:0]) * (2*bfa_pkg::WW)'(bfa_pkg::NEG_PINV);
	assign s_sum  = bfa_pkg::accumulate(s_s3, qq_s3);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_vld;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	// stage 1: add the a*b_i row into the running value
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			act_s1 <= in_bus.action;
			a_s1   <= in_bus.a;
			b_s1   <= in_bus.b;
			s_s1   <= bfa_pkg::accumulate(bfa_pkg::SW'(in_bus.t), in_bus.pp);
		end
	end

	// stage 2: reduction multiplier m
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			act_s2 <= act_s1;
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			s_s2   <= s_s1;
			m_s2   <= m_prod[bfa_pkg::WW-1:0];
		end
	end

	// stage 3: m*p row
	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			act_s3 <= act_s2;
			a_s3   <= a_s2;
			b_s3   <= b_s2;
			s_s3   <= s_s2;
			qq_s3  <= bfa_pkg::word_products(bfa_pkg::PRIME, m_s2);
		end
	end

	// stage 4: add m*p, drop the zero low word, start the next a*b_i row
	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			act_s4 <= act_s3;
			a_s4   <= a_s3;
			b_s4   <= b_s3;
			t_s4   <= s_sum[bfa_pkg::TW+bfa_pkg::WW-1:bfa_pkg::WW];
			pp_s4  <= bfa_pkg::word_products(a_s3, b_s3[bfa_pkg::WW*NXT +: bfa_pkg::WW]);
		end
	end

	assign out_vld        = vld_s4;
	assign out_bus.action = act_s4;
	assign out_bus.a      = a_s4;
	assign out_bus.b      = b_s4;
	assign out_bus.t      = t_s4;
	assign out_bus.pp     = pp_s4;

endmodule
